/* sv/pad_pkg.sv */
// Shared types, codes and constants for the potentiometer angle drive.
// Used by the request and register channel interfaces, the divider cell, the angle stage and the top level.
package pad_pkg;

  localparam int ADC_SAMPLE_W   = 10;
  localparam int ADC_BITS_DEF   = 10;
  localparam int OHM_SCALE      = 10000;
  localparam int OHM_SCALE_W    = 14;
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 24;

  localparam logic [23:0] CENTER_RESET      = 24'd10000;
  localparam logic [23:0] GAIN_RESET        = 24'd150995;
  localparam logic [14:0] ANGLE_LIMIT_RESET = 15'd11520;
  localparam logic [14:0] DEADBAND_RESET    = 15'd768;

  localparam logic signed [10:0] SPEED_MAX = 11'sd1000;

  // speed*3200/1000 equals (speed*16)/5; the division by 5 is a multiply by
  // a rounded-up reciprocal of 2^16/5, exact for every 14-bit operand.
  localparam logic [13:0] FIFTH_RECIP = 14'd13108;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER      = 8'd0,
    REG_GAIN        = 8'd1,
    REG_ANGLE_LIMIT = 8'd2,
    REG_DEADBAND    = 8'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_SPEED  = 2'd1,
    STATUS_BAD_TARGET = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_LOCK       = 2'd1,
    CMD_DRIVE_DOWN = 2'd2,
    CMD_DRIVE_UP   = 2'd3
  } motor_cmd_t;

  // Request fields that ride along the divider chain untouched.
  typedef struct packed {
    logic signed [15:0] target_angle;
    logic signed [10:0] speed_request;
  } side_t;

  // Current register settings handed to the angle stage.
  typedef struct packed {
    logic [23:0] center_resistance;
    logic [23:0] angle_gain;
    logic [14:0] angle_limit;
    logic [14:0] deadband;
  } cfg_t;

endpackage

/* sv/pad_in_if.sv */
// Request channel of the potentiometer angle drive.
// Depends on pad_pkg for the sample width.
interface pad_in_if
  import pad_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ADC_SAMPLE_W-1:0]  adc_sample;
  logic signed [15:0]       target_angle;
  logic signed [10:0]       speed_request;

  modport source (output valid, adc_sample, target_angle, speed_request, input ready);
  modport sink   (input valid, adc_sample, target_angle, speed_request, output ready);
endinterface

/* sv/pad_out_if.sv */
// Result channel of the potentiometer angle drive.
// Stand-alone; field widths are fixed.
interface pad_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         motor_cmd;
  logic [11:0]        drive_level;
  logic signed [15:0] measured_angle;

  modport source (output valid, status, motor_cmd, drive_level, measured_angle, input ready);
  modport sink   (input valid, status, motor_cmd, drive_level, measured_angle, output ready);
endinterface

/* sv/pad_cfg_if.sv */
// Register write channel of the potentiometer angle drive.
// Depends on pad_pkg for index and data widths.
interface pad_cfg_if
  import pad_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CFG_INDEX_W-1:0]  index;
  logic [CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/potentiometer_angle_deadband_drive.sv */
// Top level of the potentiometer angle drive with a hold window.
// Depends on pad_pkg, the three channel interfaces, pad_div_cell and pad_angle.
//
// Usage: each request on in_ch carries an ADC sample of the potentiometer, a
// target angle and a speed request; each request yields exactly one result on
// out_ch with a status, a motor command, a drive level and the measured angle.
// Register writes arrive on cfg, which is always ready; registers should only
// be written while no request is in flight.
//
// The resistance raw*10000/(2^ADC_BITS-raw) is computed by a row of
// ADC_BITS+14 identical divider cells, each producing one quotient bit per
// cycle while the pipe is not held and passing its partial remainder to
// the next cell. A request passes through one input register, the cell row
// and three angle stages (offset, gain multiply, saturate and decide). A new
// request is accepted every cycle unless a result is held at the output.
//
// Reset clears all valid flags and loads the register defaults. When the
// receiver stalls a waiting result, the whole pipe holds and in_ch.ready
// drops in the same cycle; it rises again as soon as the result is taken.
module potentiometer_angle_deadband_drive
  import pad_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  pad_in_if.sink    in_ch,
  pad_out_if.source out_ch,
  pad_cfg_if.sink   cfg
);

  localparam int NW = ADC_BITS + OHM_SCALE_W;
  localparam int DW = ADC_BITS + 1;
  localparam logic [DW-1:0] FULL_SCALE = DW'(1) << ADC_BITS;

  // Global advance: the pipe moves unless a finished result is being held.
  logic en;

  // Register file.
  cfg_t cfg_regs;

  // Input register and converter value.
  logic [ADC_BITS-1:0] raw;
  logic                s0_valid;
  side_t               s0_side;
  logic [NW-1:0]       s0_num;
  logic [DW-1:0]       s0_div;

  // Divider chain links.
  logic          c_valid [NW+1];
  side_t         c_side  [NW+1];
  logic [NW-1:0] c_num   [NW+1];
  logic [DW-1:0] c_rem   [NW+1];
  logic [NW-1:0] c_quo   [NW+1];
  logic [DW-1:0] c_div   [NW+1];

  status_t    out_status;
  motor_cmd_t out_cmd;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready   = 1'b1;

  // Register writes; an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.center_resistance <= CENTER_RESET;
      cfg_regs.angle_gain        <= GAIN_RESET;
      cfg_regs.angle_limit       <= ANGLE_LIMIT_RESET;
      cfg_regs.deadband          <= DEADBAND_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER:      cfg_regs.center_resistance <= cfg.data;
        REG_GAIN:        cfg_regs.angle_gain        <= cfg.data;
        REG_ANGLE_LIMIT: cfg_regs.angle_limit       <= cfg.data[14:0];
        REG_DEADBAND:    cfg_regs.deadband          <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  // Only the low ADC_BITS bits of the sample count; a wider converter setting
  // sees the sample zero extended.
  generate
    if (ADC_BITS <= ADC_SAMPLE_W) begin : g_raw_narrow
      assign raw = in_ch.adc_sample[ADC_BITS-1:0];
    end else begin : g_raw_wide
      assign raw = ADC_BITS'(in_ch.adc_sample);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side.target_angle  <= in_ch.target_angle;
      s0_side.speed_request <= in_ch.speed_request;
      s0_num <= NW'(raw) * NW'(OHM_SCALE);
      s0_div <= FULL_SCALE - DW'(raw);
    end
  end

  assign c_valid[0] = s0_valid;
  assign c_side[0]  = s0_side;
  assign c_num[0]   = s0_num;
  assign c_rem[0]   = '0;
  assign c_quo[0]   = '0;
  assign c_div[0]   = s0_div;

  generate
    for (genvar i = 0; i < NW; i++) begin : g_cell
      pad_div_cell #(.NW(NW), .DW(DW)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .valid_in  (c_valid[i]),
        .side_in   (c_side[i]),
        .num_in    (c_num[i]),
        .rem_in    (c_rem[i]),
        .quo_in    (c_quo[i]),
        .div_in    (c_div[i]),
        .valid_out (c_valid[i+1]),
        .side_out  (c_side[i+1]),
        .num_out   (c_num[i+1]),
        .rem_out   (c_rem[i+1]),
        .quo_out   (c_quo[i+1]),
        .div_out   (c_div[i+1])
      );
    end
  endgenerate

  // The last cell's quotient is the truncated resistance in ohms.
  pad_angle #(.NW(NW)) u_angle (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .valid_in       (c_valid[NW]),
    .side_in        (c_side[NW]),
    .ohms           (c_quo[NW]),
    .cfg            (cfg_regs),
    .valid_out      (out_ch.valid),
    .status         (out_status),
    .motor_cmd      (out_cmd),
    .drive_level    (out_ch.drive_level),
    .measured_angle (out_ch.measured_angle)
  );

  assign out_ch.status    = out_status;
  assign out_ch.motor_cmd = out_cmd;

  // A held result must stall the input side.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while a result was stalled");

  // An error status never carries a motor command or a drive level.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_status != STATUS_OK) |->
      (out_cmd == CMD_NONE && out_ch.drive_level == 12'd0))
    else $error("error status with a motor command");

  // Lock and idle commands carry no drive level.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_cmd == CMD_LOCK || out_cmd == CMD_NONE)) |->
      out_ch.drive_level == 12'd0)
    else $error("drive level without a drive command");

  // A result stalled at the output holds its value.
  assert property (@(posedge clk) disable iff (rst)
    $past(out_ch.valid && !out_ch.ready) && !$past(rst) |->
      $stable(out_ch.measured_angle))
    else $error("stalled result changed");

endmodule

/* sv/pad_div_cell.sv */
// One restoring-division step of the resistance divider chain.
// Depends on pad_pkg for the side payload type.
module pad_div_cell
  import pad_pkg::*;
#(
  parameter int NW = 24,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  side_t         side_in,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] quo_in,
  input  logic [DW-1:0] div_in,
  output logic          valid_out,
  output side_t         side_out,
  output logic [NW-1:0] num_out,
  output logic [DW-1:0] rem_out,
  output logic [NW-1:0] quo_out,
  output logic [DW-1:0] div_out
);

  logic [DW:0]   rem_shift;
  logic          fits;
  logic [DW:0]   rem_sub;

  always_comb begin
    rem_shift = {rem_in, num_in[NW-1]};
    fits      = rem_shift >= {1'b0, div_in};
    rem_sub   = fits ? (rem_shift - {1'b0, div_in}) : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      num_out  <= {num_in[NW-2:0], 1'b0};
      // The remainder stays below the divisor, so the top bit is always zero.
      rem_out  <= rem_sub[DW-1:0];
      quo_out  <= {quo_in[NW-2:0], fits};
      div_out  <= div_in;
    end
  end

endmodule

/* sv/pad_angle.sv */
// Angle scaling, saturation and drive decision after the divider chain.
// Depends on pad_pkg for codes, the side payload and register types.
module pad_angle
  import pad_pkg::*;
#(
  parameter int NW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  side_t         side_in,
  input  logic [NW-1:0] ohms,
  input  cfg_t          cfg,
  output logic          valid_out,
  output status_t       status,
  output motor_cmd_t    motor_cmd,
  output logic [11:0]   drive_level,
  output logic signed [15:0] measured_angle
);

  localparam int DFW = ((NW > 24) ? NW : 24) + 1;
  localparam int PW  = DFW + 25;
  localparam int SW  = PW - 16;

  // Stage A: offset from center and drive level.
  logic               valid_a;
  side_t              side_a;
  logic signed [DFW-1:0] diff_a;
  logic [11:0]        level_a;
  logic [13:0]        speed16;
  logic [27:0]        level_prod;

  // Stage B: product with the gain.
  logic               valid_b;
  side_t              side_b;
  logic [11:0]        level_b;
  logic signed [PW-1:0] prod_b;

  // Stage C terms.
  logic signed [SW-1:0] shifted;
  logic               sat_hi;
  logic               sat_lo;
  logic signed [15:0] angle_c;
  logic signed [17:0] win_hi;
  logic signed [17:0] win_lo;
  logic signed [17:0] angle_x;
  logic signed [17:0] target_x;
  logic signed [17:0] max_x;
  logic               speed_bad;
  logic               target_bad;
  status_t            status_next;
  motor_cmd_t         cmd_next;
  logic [11:0]        level_next;

  always_comb begin
    speed16    = {side_in.speed_request[9:0], 4'b0000};
    level_prod = speed16 * FIFTH_RECIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      valid_a   <= valid_in;
      valid_b   <= valid_a;
      valid_out <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a  <= side_in;
      diff_a  <= $signed(DFW'(ohms)) - $signed(DFW'(cfg.center_resistance));
      level_a <= level_prod[27:16];
      side_b  <= side_a;
      level_b <= level_a;
      prod_b  <= PW'(diff_a) * $signed(PW'({1'b0, cfg.angle_gain}));
    end
  end

  always_comb begin
    // Arithmetic shift floors, matching the rounding of negative angles.
    shifted = SW'(prod_b >>> 16);
    sat_hi  = !shifted[SW-1] && (|shifted[SW-2:15]);
    sat_lo  = shifted[SW-1] && !(&shifted[SW-2:15]);
    if (sat_hi) begin
      angle_c = 16'sh7fff;
    end else if (sat_lo) begin
      angle_c = -16'sh8000;
    end else begin
      angle_c = shifted[15:0];
    end
    angle_x  = 18'(angle_c);
    target_x = 18'(side_b.target_angle);
    max_x    = $signed({3'b000, cfg.angle_limit});
    win_hi   = target_x + $signed({3'b000, cfg.deadband});
    win_lo   = target_x - $signed({3'b000, cfg.deadband});
    speed_bad  = side_b.speed_request < 11'sd0 || side_b.speed_request > SPEED_MAX;
    target_bad = target_x > max_x || target_x < -max_x;
    status_next = STATUS_OK;
    cmd_next    = CMD_NONE;
    level_next  = '0;
    if (speed_bad) begin
      status_next = STATUS_BAD_SPEED;
    end else if (target_bad) begin
      status_next = STATUS_BAD_TARGET;
    end else if (angle_x <= win_hi && angle_x >= win_lo) begin
      cmd_next = CMD_LOCK;
    end else begin
      cmd_next   = (angle_x > win_hi) ? CMD_DRIVE_UP : CMD_DRIVE_DOWN;
      level_next = level_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status         <= status_next;
      motor_cmd      <= cmd_next;
      drive_level    <= level_next;
      measured_angle <= angle_c;
    end
  end

endmodule
